### rtl/core/a2g7_pkg.sv
// Shared types, constants and character map for the GSM 7-bit encoder/packer.
package a2g7_pkg;

    localparam int unsigned CNT_W      = 8;
    localparam int unsigned SEPT_W     = 7;
    localparam int unsigned FILL_W     = 3;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned Q_DEPTH    = 2;
    localparam int unsigned Q_PTR_W    = 1;
    localparam int unsigned Q_CNT_W    = 2;

    localparam logic [SEPT_W-1:0] ESC_SEPTET   = 7'h1B;
    localparam logic [CNT_W-1:0]  CNT_SAT      = 8'hFF;
    localparam int unsigned       EXT_BIT      = 7;
    localparam logic              REG_PACK_IDX = 1'b0;

    localparam logic [1:0] NSEP_NONE = 2'd0;
    localparam logic [1:0] NSEP_ONE  = 2'd1;
    localparam logic [1:0] NSEP_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0]        nsep;
        logic [SEPT_W-1:0] code;
        logic              pack;
        logic              fin;
        logic [CNT_W-1:0]  cons;
        logic [CNT_W-1:0]  sept;
    } a2g7_desc_t;

    localparam logic [7:0] GSM_MAP [256] = '{
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
        8'h20, 8'h20, 8'h0A, 8'h20, 8'h20, 8'h0D, 8'h20, 8'h20,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
        8'h20, 8'h21, 8'h22, 8'h23, 8'h02, 8'h25, 8'h26, 8'h27,
        8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
        8'h00, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
        8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F,
        8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
        8'h58, 8'h59, 8'h5A, 8'hBC, 8'hAF, 8'hBE, 8'h94, 8'h11,
        8'h27, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
        8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F,
        8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
        8'h78, 8'h79, 8'h7A, 8'hA8, 8'hC0, 8'hA9, 8'hBD, 8'h20,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
        8'h20, 8'h40, 8'h63, 8'h01, 8'hE5, 8'h03, 8'h53, 8'h5F,
        8'h73, 8'h63, 8'h20, 8'h20, 8'h20, 8'h2D, 8'h20, 8'h20,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h5A, 8'h75, 8'h0A, 8'h20,
        8'h7A, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h59, 8'h60,
        8'h41, 8'h41, 8'h41, 8'h41, 8'h5B, 8'h0E, 8'h1C, 8'h09,
        8'h45, 8'h1F, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49, 8'h49,
        8'h44, 8'h5D, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h5C, 8'h2A,
        8'h0B, 8'h55, 8'h55, 8'h55, 8'h5E, 8'h59, 8'h20, 8'h1E,
        8'h7F, 8'h61, 8'h61, 8'h61, 8'h7B, 8'h0F, 8'h1D, 8'h63,
        8'h04, 8'h05, 8'h65, 8'h65, 8'h07, 8'h69, 8'h69, 8'h69,
        8'h20, 8'h7D, 8'h08, 8'h6F, 8'h6F, 8'h6F, 8'h7C, 8'h2F,
        8'h0C, 8'h06, 8'h75, 8'h75, 8'h7E, 8'h79, 8'h20, 8'h79
    };

endpackage

### rtl/core/ascii_to_gsm7_encoder_packer_core.sv
// Top level of the ISO-8859-15 to GSM 7-bit encoder and SMS septet packer.
// Each character maps to one septet, or to the escape septet plus one for
// extension characters; septets leave raw or packed LSB-first into octets.
// A character is taken each cycle while the two-entry descriptor queue has
// room; the packer handles one septet per cycle while the result register,
// which holds one transaction, is empty or being popped. A final character
// that leaves bits pending or brings no septet adds a padded octet or a
// status transaction. The result register is reloaded in the cycle it is
// popped. MAX_SEPTETS (2..255) bounds the septets of one message.
module ascii_to_gsm7_encoder_packer_core #(
    parameter int unsigned MAX_SEPTETS = 160
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [a2g7_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [a2g7_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [a2g7_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        ascii_char,
    input  logic                              is_final,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        out_byte,
    output logic                              byte_valid,
    output logic                              is_last,
    output logic [7:0]                        chars_consumed,
    output logic [7:0]                        septets_total,
    output logic [7:0]                        bytes_total
);
    import a2g7_pkg::*;

    logic       pack_reg, pack_next;
    logic       reg_sel;
    logic       accept;
    logic       q_wr;
    logic       q_full;
    logic       q_valid;
    logic       q_rd;
    a2g7_desc_t q_wdata;
    a2g7_desc_t q_rdata;

    always_comb
    begin
        pready    = 1'b1;
        reg_sel   = (paddr[APB_ADDR_W-1] == REG_PACK_IDX);
        prdata    = reg_sel ? {{(APB_DATA_W-1){1'b0}}, pack_reg} : '0;
        pack_next = pack_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            pack_next = pwdata[0];
        end
        full   = q_full;
        accept = push && !q_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_reg <= 1'b1;
        end
        else
        begin
            pack_reg <= pack_next;
        end
    end

    a2g7_front #(
        .MAX_SEPTETS (MAX_SEPTETS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .ascii_char  (ascii_char),
        .is_final    (is_final),
        .pack_enable (pack_reg),
        .q_wr        (q_wr),
        .q_wdata     (q_wdata)
    );

    a2g7_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .rd    (q_rd),
        .rdata (q_rdata),
        .full  (q_full),
        .valid (q_valid)
    );

    a2g7_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .desc_valid     (q_valid),
        .desc           (q_rdata),
        .desc_pop       (q_rd),
        .pop            (pop),
        .empty          (empty),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .is_last        (is_last),
        .chars_consumed (chars_consumed),
        .septets_total  (septets_total),
        .bytes_total    (bytes_total)
    );

endmodule

### rtl/core/a2g7_front.sv
// Front end: character lookup, septet limit check and per-message character counts.
module a2g7_front #(
    parameter int unsigned MAX_SEPTETS = 160
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            ascii_char,
    input  logic                  is_final,
    input  logic                  pack_enable,
    output logic                  q_wr,
    output a2g7_pkg::a2g7_desc_t  q_wdata
);
    import a2g7_pkg::*;

    localparam logic [CNT_W:0] MAX_S = (CNT_W+1)'(MAX_SEPTETS);

    logic [CNT_W-1:0] sept_reg, sept_next;
    logic [CNT_W-1:0] cons_reg, cons_next;
    logic             stopped_reg, stopped_next;

    logic [7:0]       code;
    logic             is_ext;
    logic             fits;
    logic [1:0]       nsep;
    logic [CNT_W-1:0] sept_new;
    logic [CNT_W-1:0] cons_new;
    logic             stopped_new;

    always_comb
    begin
        code   = GSM_MAP[ascii_char];
        is_ext = code[EXT_BIT];
        if (is_ext)
        begin
            fits = ({1'b0, sept_reg} + (CNT_W+1)'(1)) < MAX_S;
        end
        else
        begin
            fits = {1'b0, sept_reg} < MAX_S;
        end

        nsep        = NSEP_NONE;
        stopped_new = stopped_reg;
        if (!stopped_reg)
        begin
            if (fits)
            begin
                nsep = is_ext ? NSEP_TWO : NSEP_ONE;
            end
            else
            begin
                stopped_new = 1'b1;
            end
        end

        sept_new = sept_reg + CNT_W'(nsep);
        cons_new = cons_reg;
        if (nsep != NSEP_NONE && cons_reg != CNT_SAT)
        begin
            cons_new = cons_reg + CNT_W'(1);
        end

        q_wdata.nsep = nsep;
        q_wdata.code = code[SEPT_W-1:0];
        q_wdata.pack = pack_enable;
        q_wdata.fin  = is_final;
        q_wdata.cons = cons_new;
        q_wdata.sept = sept_new;
        q_wr         = accept && (nsep != NSEP_NONE || is_final);

        sept_next    = sept_reg;
        cons_next    = cons_reg;
        stopped_next = stopped_reg;
        if (accept)
        begin
            if (is_final)
            begin
                sept_next    = '0;
                cons_next    = '0;
                stopped_next = 1'b0;
            end
            else
            begin
                sept_next    = sept_new;
                cons_next    = cons_new;
                stopped_next = stopped_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sept_reg    <= '0;
            cons_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            sept_reg    <= sept_next;
            cons_reg    <= cons_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

### rtl/core/a2g7_queue.sv
// Two-entry descriptor queue between the front end and the packer.
module a2g7_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  a2g7_pkg::a2g7_desc_t  wdata,
    input  logic                  rd,
    output a2g7_pkg::a2g7_desc_t  rdata,
    output logic                  full,
    output logic                  valid
);
    import a2g7_pkg::*;

    a2g7_desc_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg, wptr_next;
    logic [Q_PTR_W-1:0] rptr_reg, rptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_wr;
    logic               do_rd;

    always_comb
    begin
        full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
        valid = (cnt_reg != '0);
        rdata = mem_reg[rptr_reg];
        do_wr = wr && !full;
        do_rd = rd && valid;

        wptr_next = do_wr ? wptr_reg + Q_PTR_W'(1) : wptr_reg;
        rptr_next = do_rd ? rptr_reg + Q_PTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

### rtl/core/a2g7_back.sv
// Back end: septet packing, final flush, totals and the result register.
module a2g7_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  desc_valid,
    input  a2g7_pkg::a2g7_desc_t  desc,
    output logic                  desc_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic [7:0]            out_byte,
    output logic                  byte_valid,
    output logic                  is_last,
    output logic [7:0]            chars_consumed,
    output logic [7:0]            septets_total,
    output logic [7:0]            bytes_total
);
    import a2g7_pkg::*;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SEPT_W-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]  oct_reg, oct_next;
    logic [1:0]        idx_reg, idx_next;

    logic              ovalid_reg, ovalid_next;
    logic [7:0]        obyte_reg, obyte_next;
    logic              obv_reg, obv_next;
    logic              olast_reg, olast_next;
    logic [CNT_W-1:0]  ocons_reg, ocons_next;
    logic [CNT_W-1:0]  osept_reg, osept_next;
    logic [CNT_W-1:0]  obytes_reg, obytes_next;

    logic              step;
    logic [1:0]        rem;
    logic [SEPT_W-1:0] septet;
    logic [13:0]       acc;
    logic              emit;
    logic              produce;
    logic [7:0]        byte_val;
    logic [FILL_W-1:0] f1;
    logic [FILL_W-1:0] f2;
    logic [SEPT_W-1:0] b1;
    logic              byte2;
    logic              later;
    logic              last;
    logic              done;
    logic [CNT_W-1:0]  oct_inc;

    always_comb
    begin
        step   = desc_valid && (!ovalid_reg || pop);
        rem    = desc.nsep - idx_reg;
        septet = (desc.nsep == NSEP_TWO && idx_reg == 2'd0) ? ESC_SEPTET : desc.code;
        acc    = {7'b0, buf_reg} | ({7'b0, septet} << fill_reg);

        emit     = 1'b0;
        produce  = 1'b0;
        byte_val = '0;
        f1       = fill_reg;
        b1       = buf_reg;
        byte2    = 1'b0;
        f2       = fill_reg;
        last     = 1'b0;
        done     = 1'b1;

        if (rem != NSEP_NONE)
        begin
            if (desc.pack)
            begin
                emit     = (fill_reg != '0);
                byte_val = acc[7:0];
                if (fill_reg != '0)
                begin
                    f1 = fill_reg - FILL_W'(1);
                    b1 = {1'b0, acc[13:8]};
                end
                else
                begin
                    f1 = FILL_W'(7);
                    b1 = septet;
                end
            end
            else
            begin
                emit     = 1'b1;
                byte_val = {1'b0, septet};
            end
            f2 = f1;
            if (rem == NSEP_TWO)
            begin
                byte2 = !desc.pack || (f1 != '0);
                if (desc.pack)
                begin
                    f2 = (f1 == '0) ? FILL_W'(7) : f1 - FILL_W'(1);
                end
            end
            later   = byte2 || (desc.fin && f2 != '0);
            last    = desc.fin && emit && !later;
            produce = emit;
            done    = (rem == NSEP_ONE) && !(desc.fin && f1 != '0);
        end
        else
        begin
            later    = 1'b0;
            emit     = (fill_reg != '0);
            byte_val = {1'b0, buf_reg};
            if (!emit)
            begin
                byte_val = '0;
            end
            last    = 1'b1;
            produce = 1'b1;
            f1      = '0;
            b1      = '0;
        end

        oct_inc  = oct_reg + CNT_W'(emit);
        desc_pop = step && done;

        fill_next = fill_reg;
        buf_next  = buf_reg;
        oct_next  = oct_reg;
        idx_next  = idx_reg;
        if (step)
        begin
            if (done)
            begin
                idx_next = '0;
                if (desc.fin)
                begin
                    fill_next = '0;
                    buf_next  = '0;
                    oct_next  = '0;
                end
                else
                begin
                    fill_next = f1;
                    buf_next  = b1;
                    oct_next  = oct_inc;
                end
            end
            else
            begin
                idx_next  = idx_reg + 2'd1;
                fill_next = f1;
                buf_next  = b1;
                oct_next  = oct_inc;
            end
        end

        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        obv_next    = obv_reg;
        olast_next  = olast_reg;
        ocons_next  = ocons_reg;
        osept_next  = osept_reg;
        obytes_next = obytes_reg;
        if (ovalid_reg && pop)
        begin
            ovalid_next = 1'b0;
        end
        if (step && produce)
        begin
            ovalid_next = 1'b1;
            obyte_next  = byte_val;
            obv_next    = emit;
            olast_next  = last;
            ocons_next  = last ? desc.cons : '0;
            osept_next  = last ? desc.sept : '0;
            obytes_next = last ? oct_inc : '0;
        end

        empty          = !ovalid_reg;
        out_byte       = obyte_reg;
        byte_valid     = obv_reg;
        is_last        = olast_reg;
        chars_consumed = ocons_reg;
        septets_total  = osept_reg;
        bytes_total    = obytes_reg;
    end

    always_ff @(posedge clk)
    begin
        obyte_reg  <= obyte_next;
        obv_reg    <= obv_next;
        olast_reg  <= olast_next;
        ocons_reg  <= ocons_next;
        osept_reg  <= osept_next;
        obytes_reg <= obytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            buf_reg    <= '0;
            oct_reg    <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            buf_reg    <= buf_next;
            oct_reg    <= oct_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule
